[rtl/core/lphs_pkg.sv]
`timescale 1ns / 1ps

package lphs_pkg;

    // Fixed field widths of the item and result ports
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 32;
    localparam int HOME_W  = 8;
    localparam int COUNT_W = 9;

    // Configuration port
    localparam int CFG_W  = 9;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Register index, taken from paddr[ADDR_W-1:2]
    localparam logic REG_TABLE_SIZE = 1'b0;

    // Item commands; the fourth code is left undefined and gives ok=0
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the input item
        logic decode;   // classify item, start probe or finish at once
        logic read;     // read key memory and used mark at the probe slot
        logic check;    // evaluate the probed slot, commit or advance
        logic emit;     // move the result into the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic dec_done;   // clear, undefined command or home slot out of range
        logic probe_done; // probed slot ends the search
        logic out_free;   // output register can take a result this cycle
    } dp_stat_t;

endpackage

[rtl/core/lphs_datapath.sv]
`timescale 1ns / 1ps

module lphs_datapath
    import lphs_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int KW    = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [CMD_W-1:0]   command,
    input  logic [KEY_W-1:0]   key,
    input  logic [HOME_W-1:0]  home_slot,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    output logic [CFG_W-1:0]   table_size,
    input  logic               out_stall,
    output logic               out_valid,
    output logic               ok,
    output logic [COUNT_W-1:0] used_count
);

    localparam int IW = $clog2(DEPTH);

    // Control state
    logic [CFG_W-1:0]   table_size_reg;
    logic [DEPTH-1:0]   used_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               out_valid_reg;

    // Item and probe payload
    cmd_t               cmd_reg;
    logic [KW-1:0]      key_reg;
    logic [HOME_W-1:0]  home_reg;
    logic [IW-1:0]      idx_reg;
    logic [CFG_W-1:0]   steps_reg;
    logic               ok_reg;
    logic               used_q_reg;
    logic [KW-1:0]      rdata_reg;
    logic               out_ok_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [KW-1:0]      slot_key_mem [DEPTH];

    logic [CFG_W-1:0]   n_now;
    logic [CFG_W-1:0]   home_ext;
    logic [CFG_W-1:0]   idx_inc;
    logic [IW-1:0]      idx_next;
    logic               dec_clear;
    logic               dec_probe;
    logic               is_insert;
    logic               key_hit;
    logic               last_step;
    logic               probe_ok;
    logic               probe_done;
    logic               mem_we;

    // Slots in use: zero counts as one, anything above the build caps
    always_comb
    begin
        if (table_size_reg == '0)
            n_now = CFG_W'(1);
        else if (table_size_reg > CFG_W'(DEPTH))
            n_now = CFG_W'(DEPTH);
        else
            n_now = table_size_reg;
    end

    // Item classification
    assign home_ext  = CFG_W'(home_reg);
    assign dec_clear = (cmd_reg == CMD_CLEAR);
    assign dec_probe = ((cmd_reg == CMD_INSERT) || (cmd_reg == CMD_LOOKUP))
                       && (home_ext < n_now);

    // Probe evaluation on the registered slot contents
    assign is_insert  = (cmd_reg == CMD_INSERT);
    assign key_hit    = (rdata_reg == key_reg);
    assign last_step  = ((steps_reg + CFG_W'(1)) == n_now);
    assign probe_ok   = is_insert ? !used_q_reg : (used_q_reg && key_hit);
    assign probe_done = !used_q_reg || (!is_insert && key_hit) || last_step;
    assign mem_we     = cmd.check && is_insert && !used_q_reg;

    // Linear step with wrap at the table size
    assign idx_inc  = CFG_W'(idx_reg) + CFG_W'(1);
    assign idx_next = (idx_inc == n_now) ? '0 : idx_inc[IW-1:0];

    assign stat.dec_done   = !dec_probe;
    assign stat.probe_done = probe_done;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    // Key memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_key_mem[idx_reg] <= key_reg;
        if (cmd.read)
            rdata_reg <= slot_key_mem[idx_reg];
    end

    // Table size, used marks and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= CFG_W'(DEPTH);
            used_reg       <= '0;
            count_reg      <= '0;
        end
        else if (cfg_we)
        begin
            table_size_reg <= cfg_wdata;
            used_reg       <= '0;
            count_reg      <= '0;
        end
        else if (cmd.decode && dec_clear)
        begin
            used_reg  <= '0;
            count_reg <= '0;
        end
        else if (mem_we)
        begin
            used_reg[idx_reg] <= 1'b1;
            count_reg         <= count_reg + COUNT_W'(1);
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Item capture, probe pointer and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= cmd_t'(command);
            key_reg  <= key[KW-1:0];
            home_reg <= home_slot;
        end
        if (cmd.decode)
        begin
            ok_reg    <= dec_clear;
            idx_reg   <= home_ext[IW-1:0];
            steps_reg <= '0;
        end
        if (cmd.read)
            used_q_reg <= used_reg[idx_reg];
        if (cmd.check)
        begin
            if (probe_done)
                ok_reg <= probe_ok;
            else
            begin
                idx_reg   <= idx_next;
                steps_reg <= steps_reg + CFG_W'(1);
            end
        end
        if (cmd.emit)
        begin
            out_ok_reg    <= ok_reg;
            out_count_reg <= count_reg;
        end
    end

    assign table_size = table_size_reg;
    assign out_valid  = out_valid_reg;
    assign ok         = out_ok_reg;
    assign used_count = out_count_reg;

`ifndef SYNTHESIS
    // Fill count never exceeds the slots in use
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= n_now)
        else $error("used count above table size");

    // A committed insert adds exactly one used slot
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && !cfg_we) |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("insert did not bump used count");

    // Clear empties the table
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decode && dec_clear) |=> (count_reg == '0 && used_reg == '0))
        else $error("clear left used slots");
`endif

endmodule

[rtl/core/lphs_controller.sv]
`timescale 1ns / 1ps

module lphs_controller
    import lphs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                if (stat.dec_done)
                    state_next = ST_DONE;
                else
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (stat.probe_done)
                    state_next = ST_DONE;
                else
                    state_next = ST_READ;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_DECODE:
                cmd.decode = 1'b1;
            ST_READ:
                cmd.read = 1'b1;
            ST_CHECK:
                cmd.check = 1'b1;
            ST_DONE:
                cmd.emit = stat.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

[rtl/core/linear_probe_hash_set_unit.sv]
`timescale 1ns / 1ps
// Linear-probing hash set with insert, lookup and clear commands.
// Input channel: in_valid / in_stall carrying command, key and home_slot;
// the caller hashes the key and supplies the home slot.
// Output channel: out_valid / out_stall carrying ok and used_count, one
// result per item, in item order.
// APB port: register 0 (byte address 0) is table_size; writing it also
// empties the table. Write only while no item is in flight.
// Timing: an item passes its accept cycle, a decode state, for each probed
// slot a registered key-memory read followed by a compare, and a state that
// loads the output register. Clear, an undefined command or a home slot past
// the table size skips the probe; a probe visits from 1 slot up to the table
// size. The single key-memory read port sets the probe rate. The next item is
// accepted once the current one has been moved to the output register.
// Reset empties every slot, sets table_size to the built slot count and
// needs no clearing pass. If the receiver stalls, the result holds in the
// output register; a following item is still processed and then waits
// for the register to free up.
module linear_probe_hash_set_unit
    import lphs_pkg::*;
#(
    parameter int SLOTS    = 256,
    parameter int KEY_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   command,
    input  logic [KEY_W-1:0]   key,
    input  logic [HOME_W-1:0]  home_slot,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic [COUNT_W-1:0] used_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    // The 9-bit table size limits the reachable slots
    localparam int MAX_N = (1 << CFG_W) - 1;
    localparam int DEPTH = (SLOTS < MAX_N) ? SLOTS : MAX_N;
    localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic             cfg_we;
    logic             reg_sel;
    logic [CFG_W-1:0] table_size;

    // APB decode: no wait states
    assign pready  = 1'b1;
    assign reg_sel = (paddr[ADDR_W-1:2] == REG_TABLE_SIZE);
    assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? DATA_W'(table_size) : '0;

    lphs_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    lphs_datapath #(
        .DEPTH (DEPTH),
        .KW    (KW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .command    (command),
        .key        (key),
        .home_slot  (home_slot),
        .cfg_we     (cfg_we),
        .cfg_wdata  (pwdata[CFG_W-1:0]),
        .table_size (table_size),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .ok         (ok),
        .used_count (used_count)
    );

endmodule

[bench/tb_linear_probe_hash_set_unit.sv]
`timescale 1ns / 1ps

module tb_linear_probe_hash_set_unit;
    import lphs_pkg::*;

    localparam int NUM_SLOTS       = 256;
    localparam int PHASES          = 11;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int POOL_KEYS       = 16;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLES    = 20;

    // The fourth command code has no enum member; the block ignores it
    localparam logic [CMD_W-1:0]  CMD_UNDEF       = 2'd3;
    localparam logic [ADDR_W-1:0] TABLE_SIZE_ADDR = {REG_TABLE_SIZE, 2'b00};

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic [HOME_W-1:0] home;
    } set_item_t;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] count;
    } set_reply_t;

    // DUT ports
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [CMD_W-1:0]   command   = '0;
    logic [KEY_W-1:0]   key       = '0;
    logic [HOME_W-1:0]  home_slot = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               ok;
    logic [COUNT_W-1:0] used_count;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [ADDR_W-1:0]  paddr     = '0;
    logic [DATA_W-1:0]  pwdata    = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // Shadow copy of the table
    logic [KEY_W-1:0] shadow_keys [NUM_SLOTS];
    logic             shadow_used [NUM_SLOTS];
    int unsigned      shadow_count;
    logic [CFG_W-1:0] shadow_table_size;

    set_item_t  pending_items [$];
    set_reply_t expected_replies [$];
    logic [KEY_W-1:0] key_pool [POOL_KEYS];

    int error_count = 0;
    int idle_cycles = 0;
    int in_accepts  = 0;
    int in_seen     = 0;
    int hold_req    = 0;
    int hold_seen   = 0;

    // Driver and receiver working variables
    int        burst_left = 0;
    int        gap_left   = 0;
    int        hold_left  = 0;
    int        rx_mode    = 0;
    int        rx_left    = 0;
    logic      drv_taken;
    logic      drv_valid;
    logic      rx_stall;
    set_item_t drv_item;

    // Monitor working variables
    logic       mon_active;
    set_reply_t mon_exp;
    set_reply_t mon_pred;

    linear_probe_hash_set_unit #(
        .SLOTS    (NUM_SLOTS),
        .KEY_BITS (KEY_W)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .key        (key),
        .home_slot  (home_slot),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .used_count (used_count),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic empty_shadow_table();
        int i;
        begin
            for (i = 0; i < NUM_SLOTS; i++)
                shadow_used[i] = 1'b0;
            shadow_count = 0;
        end
    endtask

    // Apply one command to the shadow table and return the reply it gives
    task automatic apply_set_command(input set_item_t item, output set_reply_t reply);
        int  n;
        int  i;
        int  idx;
        bit  stop;
        begin
            if (shadow_table_size == 0)
                n = 1;
            else if (shadow_table_size > NUM_SLOTS)
                n = NUM_SLOTS;
            else
                n = shadow_table_size;
            reply.ok = 1'b0;
            stop = 1'b0;
            if (item.cmd == CMD_CLEAR)
            begin
                empty_shadow_table();
                reply.ok = 1'b1;
            end
            else if ((item.cmd == CMD_INSERT || item.cmd == CMD_LOOKUP) && item.home < n)
            begin
                // Linear probe from the home slot, wrapping at the table size
                for (i = 0; i < n && !stop; i++)
                begin
                    idx = item.home + i;
                    if (idx >= n)
                        idx -= n;
                    if (item.cmd == CMD_INSERT)
                    begin
                        if (!shadow_used[idx])
                        begin
                            shadow_used[idx] = 1'b1;
                            shadow_keys[idx] = item.key;
                            shadow_count++;
                            reply.ok = 1'b1;
                            stop = 1'b1;
                        end
                    end
                    else
                    begin
                        if (!shadow_used[idx])
                            stop = 1'b1;
                        else if (shadow_keys[idx] == item.key)
                        begin
                            reply.ok = 1'b1;
                            stop = 1'b1;
                        end
                    end
                end
            end
            reply.count = shadow_count[COUNT_W-1:0];
        end
    endtask

    task automatic queue_item(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                              input logic [HOME_W-1:0] h);
        set_item_t item;
        begin
            item.cmd  = c;
            item.key  = k;
            item.home = h;
            pending_items.push_back(item);
        end
    endtask

    // Block until every queued item is taken and every reply has come back
    task automatic wait_drained();
        begin
            @(posedge clk);
            while (pending_items.size() != 0 || in_valid || expected_replies.size() != 0)
                @(posedge clk);
        end
    endtask

    // Write table_size, then read it back
    task automatic write_table_size(input logic [CFG_W-1:0] value);
        begin
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= TABLE_SIZE_ADDR;
            pwdata  <= DATA_W'(value);
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            shadow_table_size = value;
            empty_shadow_table();

            @(negedge clk);
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            if (prdata !== DATA_W'(value))
            begin
                $display("%0t: table_size readback mismatch, expected %0d actual %0d",
                         $time, value, prdata);
                error_count++;
            end
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    function automatic logic [CFG_W-1:0] phase_table_size(input int p);
        case (p)
            0:       return 9'd256;
            1:       return 9'd1;
            2:       return 9'd0;
            3:       return 9'd2;
            4:       return 9'd511;
            5:       return 9'd5;
            6:       return 9'd16;
            7:       return 9'd257;
            8:       return 9'd64;
            9:       return 9'd3;
            default: return 9'd256;
        endcase
    endfunction

    // Item driver: bursts of items with random gaps in between
    always @(negedge clk)
    begin
        drv_taken = (in_accepts != in_seen);
        in_seen = in_accepts;
        drv_valid = in_valid && !drv_taken;
        if (!drv_valid && rst_n)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_items.size() > 0)
            begin
                drv_item = pending_items.pop_front();
                command   <= drv_item.cmd;
                key       <= drv_item.key;
                home_slot <= drv_item.home;
                drv_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        in_valid <= drv_valid;
    end

    // Result receiver: stall pattern changes mode now and then; long hold on request
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rx_stall = 1'b1;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(16, 150);
            end
            rx_left--;
            case (rx_mode)
                0:       rx_stall = 1'b0;
                1:       rx_stall = ($urandom_range(0, 3) == 0);
                2:       rx_stall = ($urandom_range(0, 3) != 0);
                default: rx_stall = ~out_stall;
            endcase
        end
        out_stall <= rx_stall;
    end

    // Monitor: predict on item acceptance, check on result acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            mon_active = 1'b0;
            if (in_valid && !in_stall)
            begin
                apply_set_command({command, key, home_slot}, mon_pred);
                expected_replies.push_back(mon_pred);
                in_accepts++;
                mon_active = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                mon_active = 1'b1;
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected result, ok %0b used_count %0d",
                             $time, ok, used_count);
                    error_count++;
                end
                else
                begin
                    mon_exp = expected_replies.pop_front();
                    if (ok !== mon_exp.ok)
                    begin
                        $display("%0t: ok mismatch, expected %0b actual %0b",
                                 $time, mon_exp.ok, ok);
                        error_count++;
                    end
                    if (used_count !== mon_exp.count)
                    begin
                        $display("%0t: used_count mismatch, expected %0d actual %0d",
                                 $time, mon_exp.count, used_count);
                        error_count++;
                    end
                end
            end
            idle_cycles = mon_active ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any accepted item or result
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus
    initial
    begin
        int p;
        int i;
        int n;
        int r;
        logic [CMD_W-1:0]  c;
        logic [KEY_W-1:0]  k;
        logic [HOME_W-1:0] h;

        shadow_table_size = CFG_W'(NUM_SLOTS);
        empty_shadow_table();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset table size: duplicates, wraparound, misses, undefined, clear
        queue_item(CMD_LOOKUP, 32'h0000_0000, 8'd0);
        queue_item(CMD_INSERT, 32'h0000_0000, 8'd0);
        queue_item(CMD_INSERT, 32'hFFFF_FFFF, 8'd255);
        queue_item(CMD_INSERT, 32'h0000_0000, 8'd0);
        queue_item(CMD_INSERT, 32'hA5A5_5A5A, 8'd255);
        queue_item(CMD_LOOKUP, 32'hA5A5_5A5A, 8'd255);
        queue_item(CMD_LOOKUP, 32'hFFFF_FFFF, 8'd255);
        queue_item(CMD_LOOKUP, 32'h1234_5678, 8'd254);
        queue_item(CMD_LOOKUP, 32'h1234_5678, 8'd255);
        queue_item(CMD_UNDEF,  32'h5555_AAAA, 8'd17);
        queue_item(CMD_CLEAR,  32'hDEAD_BEEF, 8'd200);
        queue_item(CMD_LOOKUP, 32'h0000_0000, 8'd0);
        wait_drained();

        // Directed, one slot: full table, full-turn miss, home out of range
        write_table_size(9'd1);
        queue_item(CMD_INSERT, 32'h0000_0007, 8'd0);
        queue_item(CMD_INSERT, 32'h0000_0008, 8'd0);
        queue_item(CMD_LOOKUP, 32'h0000_0007, 8'd0);
        queue_item(CMD_LOOKUP, 32'h0000_0008, 8'd0);
        queue_item(CMD_INSERT, 32'h0000_0009, 8'd1);
        queue_item(CMD_LOOKUP, 32'h0000_0007, 8'd255);
        queue_item(CMD_UNDEF,  32'hFFFF_FFFF, 8'd255);
        queue_item(CMD_CLEAR,  32'h0000_0000, 8'd0);
        wait_drained();

        // Random phases over a range of table sizes
        for (p = 0; p < PHASES; p++)
        begin
            write_table_size(phase_table_size(p));
            n = shadow_table_size == 0 ? 1 :
                (shadow_table_size > NUM_SLOTS ? NUM_SLOTS : shadow_table_size);
            for (i = 0; i < POOL_KEYS; i++)
                key_pool[i] = $urandom();
            if (p == 2 || p == 8)
                hold_req++;
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    c = CMD_CLEAR;
                else if (r < 6)
                    c = CMD_UNDEF;
                else if (r < 52)
                    c = CMD_INSERT;
                else
                    c = CMD_LOOKUP;
                k = $urandom_range(0, 1) ? key_pool[$urandom_range(0, POOL_KEYS - 1)]
                                          : $urandom();
                // Mostly valid homes; full tables cluster near the top to force wrap
                if (n < NUM_SLOTS && $urandom_range(0, 9) == 0)
                    h = 8'($urandom_range(n, NUM_SLOTS - 1));
                else if (n == NUM_SLOTS && $urandom_range(0, 1) == 0)
                    h = 8'd248 + 8'($urandom_range(0, 7));
                else
                    h = 8'($urandom_range(0, n - 1));
                queue_item(c, k, h);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
